// File: hw/rtl/glp_pkg.sv
// Shared types and codes for the group-lasso proximal operator unit.
// Used by the top level and the shared root and divide unit; no dependencies.
package glp_pkg;

  localparam int unsigned MaxElements = 1024;
  localparam int unsigned MaxGroups   = 256;
  localparam int unsigned ValueBits   = 32;
  localparam int unsigned ElemAw      = $clog2(MaxElements);
  localparam int unsigned GroupAw     = $clog2(MaxGroups);

  localparam logic [1:0] CMD_LOAD_ELEM  = 2'd0;
  localparam logic [1:0] CMD_LOAD_GROUP = 2'd1;
  localparam logic [1:0] CMD_RUN        = 2'd2;
  localparam logic [1:0] CMD_READ_ELEM  = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_TABLE = 2'd2;

  localparam logic [1:0] REG_L1_ENABLE     = 2'd0;
  localparam logic [1:0] REG_L1_THRESHOLD  = 2'd1;
  localparam logic [1:0] REG_ELEMENT_COUNT = 2'd2;
  localparam logic [1:0] REG_GROUP_COUNT   = 2'd3;

  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } glp_iter_ctl_t;

endpackage

// File: hw/rtl/group_lasso_proximal_operator_unit.sv
// Top level of the group-lasso proximal operator unit: stores, sequencer, multiplier.
// Depends on glp_pkg and glp_root_div.
//
// Loads are answered from the idle state and a read passes through S_RD. A run walks the
// group table twice: a bounds check per group, then per group a square sum over its
// elements, a square root and a division per element for scaling, both in the shared
// root and divide unit, or zeroing when the norm does not exceed the threshold; the
// optional soft threshold is a pass over all elements before the groups. Input is stalled
// throughout a run. There is no clearing pass after reset.
module group_lasso_proximal_operator_unit import glp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [30:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [9:0]  index_i,
  input  logic signed [31:0] elem_value_i,
  input  logic [10:0] group_first_i,
  input  logic [10:0] group_last_i,
  input  logic [30:0] group_threshold_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] read_value_o,
  output logic [1:0]  status_o
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_RD    = 5'd1;
  localparam logic [4:0] S_CHK_A = 5'd2;
  localparam logic [4:0] S_CHK_D = 5'd3;
  localparam logic [4:0] S_L1_A  = 5'd4;
  localparam logic [4:0] S_L1_D  = 5'd5;
  localparam logic [4:0] S_G_A   = 5'd6;
  localparam logic [4:0] S_G_D   = 5'd7;
  localparam logic [4:0] S_SQ_A  = 5'd8;
  localparam logic [4:0] S_SQ_M  = 5'd9;
  localparam logic [4:0] S_SQ_S  = 5'd10;
  localparam logic [4:0] S_RT_W  = 5'd11;
  localparam logic [4:0] S_DEC   = 5'd12;
  localparam logic [4:0] S_ZR    = 5'd13;
  localparam logic [4:0] S_SC_A  = 5'd14;
  localparam logic [4:0] S_SC_M  = 5'd15;
  localparam logic [4:0] S_DV_W  = 5'd16;
  localparam logic [4:0] S_DV_GO = 5'd17;

  logic [ValueBits-1:0] elem_mem [MaxElements];
  logic [10:0]          gf_mem   [MaxGroups];
  logic [10:0]          gl_mem   [MaxGroups];
  logic [30:0]          gt_mem   [MaxGroups];

  logic        l1_en_q;
  logic [30:0] l1_thr_q;
  logic [10:0] elem_cnt_q;
  logic [8:0]  grp_cnt_q;

  logic [4:0]  state_q, state_d;
  logic [10:0] ej_q, ej_d;
  logic [8:0]  gi_q, gi_d;
  logic [10:0] f_q, f_d, l_q, l_d;
  logic [30:0] thr_q, thr_d;
  logic [63:0] sum_q, sum_d;
  logic [31:0] norm_q, norm_d;
  logic [31:0] k_q, k_d;
  logic        neg_q, neg_d;
  logic [63:0] prod_q, prod_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_val_q, out_val_d;
  logic [1:0]  out_st_q, out_st_d;

  logic [31:0] e_rd_q;
  logic [10:0] gf_rd_q, gl_rd_q;
  logic [30:0] gt_rd_q;

  logic [10:0] n_eff;
  logic [8:0]  g_eff;
  logic        out_free, accept;
  logic        e_we;
  logic [ElemAw-1:0] e_waddr, e_raddr;
  logic [31:0] e_wdata;
  logic [31:0] mag;
  logic [31:0] mul_b;
  logic signed [32:0] v_ext, lam_ext, l1_res;
  logic [64:0] sum_ext;
  logic [31:0] qv;
  glp_iter_ctl_t iter_ctl;
  logic        iter_done;
  logic [31:0] iter_res;
  logic [63:0] iter_op;

  assign n_eff = (elem_cnt_q > 11'(MaxElements)) ? 11'(MaxElements) : elem_cnt_q;
  assign g_eff = (grp_cnt_q > 9'(MaxGroups)) ? 9'(MaxGroups) : grp_cnt_q;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && out_free);
  assign accept = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign mag   = e_rd_q[31] ? (32'd0 - e_rd_q) : e_rd_q;
  assign mul_b = (state_q == S_SQ_M) ? mag : k_q;
  assign v_ext   = {e_rd_q[31], e_rd_q};
  assign lam_ext = {2'b00, l1_thr_q};
  assign sum_ext = {1'b0, sum_q} + {1'b0, prod_q};
  assign qv      = neg_q ? (32'd0 - iter_res) : iter_res;
  assign iter_op = (state_q == S_DV_GO) ? prod_q : (sum_ext[64] ? '1 : sum_ext[63:0]);

  always_comb begin
    if (v_ext > lam_ext) begin
      l1_res = v_ext - lam_ext;
    end else if (v_ext < -lam_ext) begin
      l1_res = v_ext + lam_ext;
    end else begin
      l1_res = '0;
    end
  end

  always_comb begin
    state_d     = state_q;
    ej_d        = ej_q;
    gi_d        = gi_q;
    f_d         = f_q;
    l_d         = l_q;
    thr_d       = thr_q;
    sum_d       = sum_q;
    norm_d      = norm_q;
    k_d         = k_q;
    neg_d       = neg_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_val_d   = out_val_q;
    out_st_d    = out_st_q;
    e_we        = 1'b0;
    e_waddr     = ej_q[ElemAw-1:0];
    e_wdata     = '0;
    e_raddr     = (state_q == S_IDLE) ? index_i : ej_q[ElemAw-1:0];
    iter_ctl    = '{start: 1'b0, sqrt_mode: 1'b1};
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_i)
            CMD_LOAD_ELEM: begin
              out_valid_d = 1'b1;
              out_val_d   = '0;
              if ({1'b0, index_i} < n_eff) begin
                e_we     = 1'b1;
                e_waddr  = index_i;
                e_wdata  = elem_value_i;
                out_st_d = STATUS_OK;
              end else begin
                out_st_d = STATUS_RANGE;
              end
            end
            CMD_LOAD_GROUP: begin
              out_valid_d = 1'b1;
              out_val_d   = '0;
              out_st_d    = ({1'b0, index_i} < 11'(MaxGroups)) ? STATUS_OK : STATUS_RANGE;
            end
            CMD_RUN: begin
              gi_d    = '0;
              state_d = S_CHK_A;
            end
            CMD_READ_ELEM: begin
              ej_d    = {1'b0, index_i};
              state_d = S_RD;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        out_valid_d = 1'b1;
        if (ej_q < n_eff) begin
          out_val_d = e_rd_q;
          out_st_d  = STATUS_OK;
        end else begin
          out_val_d = '0;
          out_st_d  = STATUS_RANGE;
        end
        state_d = S_IDLE;
      end
      S_CHK_A: begin
        if (gi_q == g_eff) begin
          gi_d = '0;
          ej_d = '0;
          state_d = l1_en_q ? S_L1_A : S_G_A;
        end else begin
          state_d = S_CHK_D;
        end
      end
      S_CHK_D: begin
        if ((gf_rd_q <= gl_rd_q) && (gl_rd_q != '0) &&
            ((gf_rd_q == '0) || (gl_rd_q > n_eff))) begin
          out_valid_d = 1'b1;
          out_val_d   = '0;
          out_st_d    = STATUS_TABLE;
          state_d     = S_IDLE;
        end else begin
          gi_d    = gi_q + 9'd1;
          state_d = S_CHK_A;
        end
      end
      S_L1_A: begin
        state_d = (ej_q == n_eff) ? S_G_A : S_L1_D;
      end
      S_L1_D: begin
        e_we    = 1'b1;
        e_wdata = l1_res[31:0];
        ej_d    = ej_q + 11'd1;
        state_d = S_L1_A;
      end
      S_G_A: begin
        if (gi_q == g_eff) begin
          out_valid_d = 1'b1;
          out_val_d   = '0;
          out_st_d    = STATUS_OK;
          state_d     = S_IDLE;
        end else begin
          state_d = S_G_D;
        end
      end
      S_G_D: begin
        f_d   = gf_rd_q;
        l_d   = gl_rd_q;
        thr_d = gt_rd_q;
        if ((gf_rd_q > gl_rd_q) || (gf_rd_q == '0)) begin
          gi_d    = gi_q + 9'd1;
          state_d = S_G_A;
        end else begin
          ej_d    = gf_rd_q - 11'd1;
          sum_d   = '0;
          state_d = S_SQ_A;
        end
      end
      S_SQ_A: state_d = S_SQ_M;
      S_SQ_M: begin
        prod_d  = mag * mul_b;
        state_d = S_SQ_S;
      end
      S_SQ_S: begin
        sum_d = sum_ext[64] ? '1 : sum_ext[63:0];
        ej_d  = ej_q + 11'd1;
        if (ej_q + 11'd1 == l_q) begin
          iter_ctl = '{start: 1'b1, sqrt_mode: 1'b1};
          state_d  = S_RT_W;
        end else begin
          state_d = S_SQ_A;
        end
      end
      S_RT_W: begin
        if (iter_done) begin
          norm_d  = iter_res;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        ej_d = f_q - 11'd1;
        if (norm_q > {1'b0, thr_q}) begin
          k_d     = norm_q - {1'b0, thr_q};
          state_d = S_SC_A;
        end else begin
          state_d = S_ZR;
        end
      end
      S_ZR: begin
        e_we = 1'b1;
        ej_d = ej_q + 11'd1;
        if (ej_q + 11'd1 == l_q) begin
          gi_d    = gi_q + 9'd1;
          state_d = S_G_A;
        end
      end
      S_SC_A: state_d = S_SC_M;
      S_SC_M: begin
        prod_d  = mag * mul_b;
        neg_d   = e_rd_q[31];
        state_d = S_DV_GO;
      end
      S_DV_GO: begin
        iter_ctl = '{start: 1'b1, sqrt_mode: 1'b0};
        state_d  = S_DV_W;
      end
      S_DV_W: begin
        if (iter_done) begin
          e_we    = 1'b1;
          e_wdata = qv;
          ej_d    = ej_q + 11'd1;
          if (ej_q + 11'd1 == l_q) begin
            gi_d    = gi_q + 9'd1;
            state_d = S_G_A;
          end else begin
            state_d = S_SC_A;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  glp_root_div u_root_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (iter_ctl),
    .operand_i (iter_op),
    .divisor_i (norm_q),
    .done_o    (iter_done),
    .result_o  (iter_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      l1_en_q     <= 1'b0;
      l1_thr_q    <= '0;
      elem_cnt_q  <= 11'd1;
      grp_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_L1_ENABLE:     l1_en_q    <= cfg_data_i[0];
          REG_L1_THRESHOLD:  l1_thr_q   <= cfg_data_i;
          REG_ELEMENT_COUNT: elem_cnt_q <= cfg_data_i[10:0];
          REG_GROUP_COUNT:   grp_cnt_q  <= cfg_data_i[8:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ej_q      <= ej_d;
    gi_q      <= gi_d;
    f_q       <= f_d;
    l_q       <= l_d;
    thr_q     <= thr_d;
    sum_q     <= sum_d;
    norm_q    <= norm_d;
    k_q       <= k_d;
    neg_q     <= neg_d;
    prod_q    <= prod_d;
    out_val_q <= out_val_d;
    out_st_q  <= out_st_d;
  end

  always_ff @(posedge clk_i) begin
    if (e_we) begin
      elem_mem[e_waddr] <= e_wdata;
    end
    e_rd_q <= elem_mem[e_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (accept && (cmd_i == CMD_LOAD_GROUP) && ({1'b0, index_i} < 11'(MaxGroups))) begin
      gf_mem[index_i[GroupAw-1:0]] <= group_first_i;
      gl_mem[index_i[GroupAw-1:0]] <= group_last_i;
      gt_mem[index_i[GroupAw-1:0]] <= group_threshold_i;
    end
    gf_rd_q <= gf_mem[gi_q[GroupAw-1:0]];
    gl_rd_q <= gl_mem[gi_q[GroupAw-1:0]];
    gt_rd_q <= gt_mem[gi_q[GroupAw-1:0]];
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_val_q;
  assign status_o     = out_st_q;

`ifndef NO_ASSERTIONS
  // The unit reports completion only while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    iter_done |-> (state_q == S_RT_W) || (state_q == S_DV_W))
    else $error("root and divide unit finished outside a wait state");

  // A word carrying an error status never carries a value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STATUS_OK) |-> (read_value_o == '0))
    else $error("error word with nonzero value");

  // Input is held off whenever the sequencer is busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o)
    else $error("input accepted while busy");
`endif

endmodule

// File: hw/rtl/glp_root_div.sv
// Shared iterative unit: 64-bit integer square root or 64 by 32 division.
// One compare-subtract step per cycle; depends on glp_pkg.
module glp_root_div import glp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  glp_iter_ctl_t ctl_i,
  input  logic [63:0]   operand_i,
  input  logic [31:0]   divisor_i,
  output logic          done_o,
  output logic [31:0]   result_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic        mode_q, mode_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [63:0] a_q, a_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;
  logic [31:0] div_q, div_d;
  logic [34:0] cand, subtr;
  logic [35:0] diff;
  logic        ge;
  logic        last;

  always_comb begin
    if (mode_q) begin
      cand  = {rem_q, a_q[63:62]};
      subtr = {1'b0, root_q, 2'b01};
    end else begin
      cand  = {2'b00, rem_q[31:0], a_q[63]};
      subtr = {3'b000, div_q};
    end
    diff = {1'b0, cand} - {1'b0, subtr};
    ge   = !diff[35];
    last = mode_q ? (cnt_q == 7'd31) : (cnt_q == 7'd63);
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    mode_d = mode_q;
    cnt_d  = cnt_q;
    a_d    = a_q;
    rem_d  = rem_q;
    root_d = root_q;
    div_d  = div_q;
    if (ctl_i.start) begin
      busy_d = 1'b1;
      mode_d = ctl_i.sqrt_mode;
      cnt_d  = '0;
      a_d    = operand_i;
      rem_d  = '0;
      root_d = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[32:0] : cand[32:0];
      if (mode_q) begin
        root_d = {root_q[30:0], ge};
        a_d    = {a_q[61:0], 2'b00};
      end else begin
        a_d = {a_q[62:0], ge};
      end
      cnt_d = cnt_q + 7'd1;
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      mode_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    div_q  <= div_d;
  end

  assign done_o   = done_q;
  assign result_o = mode_q ? root_q : a_q[31:0];

endmodule

// File: bench/group_lasso_proximal_operator_unit_tb.sv
// Self-checking bench for group_lasso_proximal_operator_unit: a directed table, then random
// phases of loads, reads, group edits and proximal runs, checked against an in-bench predictor.
// Depends on glp_pkg and the unit's RTL only.
module group_lasso_proximal_operator_unit_tb;
  import glp_pkg::*;

  localparam int unsigned ItemTarget = 1350;

  typedef struct packed {
    logic        is_cfg;
    logic        typed;
    logic [1:0]  code;
    logic [9:0]  index;
    logic [31:0] value;
    logic [10:0] first;
    logic [10:0] last;
    logic [30:0] thr;
    logic [31:0] exp_value;
    logic [1:0]  exp_status;
  } row_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [30:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  cmd_i = CMD_LOAD_ELEM;
  logic [9:0]  index_i = '0;
  logic signed [31:0] elem_value_i = '0;
  logic [10:0] group_first_i = '0;
  logic [10:0] group_last_i = '0;
  logic [30:0] group_threshold_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  logic signed [31:0] read_value_o;
  logic [1:0]  status_o;

  group_lasso_proximal_operator_unit i_dut (.*);

  always #1 clk_i = ~clk_i;

  logic signed [31:0] coeff_mem [MaxElements];
  logic [10:0] first_mem [MaxGroups];
  logic [10:0] last_mem [MaxGroups];
  logic [30:0] thr_mem [MaxGroups];
  logic        l1_on = 1'b0;
  logic [30:0] l1_level = '0;
  logic [10:0] elem_reg = 11'd1;
  logic [8:0]  group_reg = '0;

  outcome_t    awaited_words[$];
  int unsigned words_in = 0;
  int unsigned error_count = 0;
  int unsigned hold_left = 0;
  int unsigned burst_left = 0;
  bit          long_hold_done = 1'b0;

  function automatic int unsigned elems_active();
    return (elem_reg > MaxElements) ? MaxElements : elem_reg;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] a);
    logic [63:0] r, b;
    r = '0;
    b = 64'd1 << 62;
    while (b > a) b = b >> 2;
    while (b != 0) begin
      if (a >= r + b) begin
        a = a - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [1:0] proximal_step();
    int unsigned n, g, f, l;
    longint v, lam;
    logic [63:0] m, sum, norm, k, q, thr;
    logic [64:0] wide;
    n = elems_active();
    g = (group_reg > MaxGroups) ? MaxGroups : group_reg;
    for (int i = 0; i < g; i++) begin
      f = first_mem[i];
      l = last_mem[i];
      if (f <= l && l != 0 && (f == 0 || l > n)) return STATUS_TABLE;
    end
    if (l1_on) begin
      lam = l1_level;
      for (int j = 0; j < n; j++) begin
        v = coeff_mem[j];
        if (v > lam) coeff_mem[j] = v - lam;
        else if (v < -lam) coeff_mem[j] = v + lam;
        else coeff_mem[j] = 0;
      end
    end
    for (int i = 0; i < g; i++) begin
      f = first_mem[i];
      l = last_mem[i];
      thr = thr_mem[i];
      if (f > l || f == 0) continue;
      sum = '0;
      for (int j = f - 1; j < l; j++) begin
        v = coeff_mem[j];
        m = (v < 0) ? 64'(-v) : 64'(v);
        wide = {1'b0, sum} + {1'b0, m * m};
        sum = wide[64] ? '1 : wide[63:0];
      end
      norm = int_sqrt(sum);
      if (norm > thr) begin
        k = norm - thr;
        for (int j = f - 1; j < l; j++) begin
          v = coeff_mem[j];
          m = (v < 0) ? 64'(-v) : 64'(v);
          q = (m / norm) * k + ((m % norm) * k) / norm;
          coeff_mem[j] = (v < 0) ? -longint'(q) : longint'(q);
        end
      end else begin
        for (int j = f - 1; j < l; j++) coeff_mem[j] = 0;
      end
    end
    return STATUS_OK;
  endfunction

  function automatic outcome_t apply_word(row_t r);
    outcome_t o;
    o = '0;
    case (r.code)
      CMD_LOAD_ELEM: begin
        if (r.index < elems_active()) coeff_mem[r.index] = r.value;
        else o.status = STATUS_RANGE;
      end
      CMD_LOAD_GROUP: begin
        if (r.index < MaxGroups) begin
          first_mem[r.index] = r.first;
          last_mem[r.index] = r.last;
          thr_mem[r.index] = r.thr;
        end else begin
          o.status = STATUS_RANGE;
        end
      end
      CMD_RUN: o.status = proximal_step();
      default: begin
        if (r.index < elems_active()) o.value = coeff_mem[r.index];
        else o.status = STATUS_RANGE;
      end
    endcase
    return o;
  endfunction

  function automatic row_t word_row(logic [1:0] code, logic [9:0] index, logic [31:0] value,
                                    logic [10:0] first, logic [10:0] last, logic [30:0] thr);
    row_t r;
    r = '0;
    r.code = code;
    r.index = index;
    r.value = value;
    r.first = first;
    r.last = last;
    r.thr = thr;
    return r;
  endfunction

  function automatic row_t typed_row(row_t r, logic [31:0] value, logic [1:0] status);
    r.typed = 1'b1;
    r.exp_value = value;
    r.exp_status = status;
    return r;
  endfunction

  function automatic row_t reg_row(logic [1:0] index, logic [30:0] data);
    row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.code = index;
    r.value = {1'b0, data};
    return r;
  endfunction

  function automatic bit quiet_stretch();
    return words_in >= 700 && words_in < 850;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_stretch() || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2, 3, 4: return $urandom;
      default: return 32'($urandom_range(0, 32'h8_0000)) - 32'h4_0000;
    endcase
  endfunction

  function automatic logic [30:0] pick_thr();
    case ($urandom_range(0, 9))
      0: return 31'h7fff_ffff;
      1: return 31'($urandom);
      default: return 31'($urandom_range(0, 32'h3_0000));
    endcase
  endfunction

  function automatic row_t pick_group(logic [9:0] slot, int unsigned n);
    int unsigned r, f, l;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      f = $urandom_range(0, 2047);
      l = $urandom_range(0, 2047);
    end else if (r < 12) begin
      f = 0;
      l = $urandom_range(1, 1024);
    end else if (r < 18) begin
      f = (n == 0) ? 1 : $urandom_range(1, n);
      l = n + $urandom_range(1, 8);
    end else if (r < 28 || n == 0) begin
      f = $urandom_range(1, 2047);
      l = $urandom_range(0, f - 1);
    end else begin
      f = $urandom_range(1, n);
      l = $urandom_range(f, (f + 7 < n) ? f + 7 : n);
    end
    return word_row(CMD_LOAD_GROUP, slot, $urandom, 11'(f), 11'(l), pick_thr());
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch in %s at %0t: got %h, expected %h", what, $realtime, got, want);
    error_count++;
  endtask

  task automatic send_word(row_t r);
    outcome_t o;
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= r.code;
    index_i <= r.index;
    elem_value_i <= r.value;
    group_first_i <= r.first;
    group_last_i <= r.last;
    group_threshold_i <= r.thr;
    do @(posedge clk_i); while (in_stall_o);
    o = apply_word(r);
    if (r.typed) o = {r.exp_value, r.exp_status};
    awaited_words.push_back(o);
    words_in++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] index, logic [30:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (index)
      REG_L1_ENABLE: l1_on = data[0];
      REG_L1_THRESHOLD: l1_level = data;
      REG_ELEMENT_COUNT: elem_reg = data[10:0];
      default: group_reg = data[8:0];
    endcase
    @(posedge clk_i);
  endtask

  task automatic random_phase(int unsigned phase);
    int unsigned n, g, ops, runs_left, r;
    logic [10:0] n_word;
    logic [8:0] g_word;
    logic [9:0] idx;
    n_word = 11'($urandom_range(1, 24));
    g_word = 9'($urandom_range(0, 4));
    runs_left = 6;
    drain();
    if (phase == 2) begin
      n_word = 11'd2047;
      g_word = 9'd511;
      runs_left = 1;
    end else if (phase == 4) begin
      n_word = 11'd0;
    end else if (phase == 6) begin
      n_word = 11'd1024;
      g_word = 9'd256;
      runs_left = 0;
    end
    write_reg(REG_L1_ENABLE, 31'($urandom_range(0, 1)));
    write_reg(REG_L1_THRESHOLD, (phase == 5) ? 31'h7fff_ffff : 31'($urandom_range(0, 32'h2_0000)));
    write_reg(REG_ELEMENT_COUNT, 31'(n_word));
    write_reg(REG_GROUP_COUNT, 31'(g_word));
    n = elems_active();
    g = (group_reg > MaxGroups) ? MaxGroups : group_reg;
    for (int j = 0; j < n; j++)
      send_word(word_row(CMD_LOAD_ELEM, 10'(j), pick_value(), '0, '0, '0));
    for (int i = 0; i < g; i++) begin
      if (n == MaxElements) begin
        r = (i == g - 1) ? 1024 : $urandom_range(1, 1024);
        send_word(word_row(CMD_LOAD_GROUP, 10'(i), '0, 11'(r),
                           (i == 0) ? 11'd1024 : 11'((r + 5 > 1024) ? 1024 : r + 5),
                           pick_thr()));
      end else begin
        send_word(pick_group(10'(i), n));
      end
    end
    ops = (n == MaxElements) ? 30 : $urandom_range(20, 50);
    for (int k = 0; k < ops; k++) begin
      r = $urandom_range(0, 99);
      if (r < 8 && runs_left > 0) begin
        runs_left--;
        send_word(word_row(CMD_RUN, 10'($urandom), $urandom, 11'($urandom), 11'($urandom),
                           31'($urandom)));
      end else if (r < 45) begin
        idx = (n == 0 || $urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, n - 1));
        send_word(word_row(CMD_LOAD_ELEM, idx, pick_value(), 11'($urandom), 11'($urandom),
                           31'($urandom)));
      end else if (r < 80) begin
        if (n == 0 || (n < MaxElements && $urandom_range(0, 9) == 0))
          idx = 10'($urandom_range(n, MaxElements - 1));
        else
          idx = 10'($urandom_range(0, n - 1));
        send_word(word_row(CMD_READ_ELEM, idx, $urandom, 11'($urandom), 11'($urandom),
                           31'($urandom)));
      end else if (n < MaxElements) begin
        if ($urandom_range(0, 9) == 0) idx = 10'($urandom);
        else idx = 10'($urandom_range(0, (g == 0) ? 3 : g - 1));
        send_word(pick_group(idx, n));
      end
    end
    if (runs_left > 0)
      send_word(word_row(CMD_RUN, '0, '0, '0, '0, '0));
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (awaited_words.size() == 0) begin
        report_mismatch("unexpected word", read_value_o, '0);
      end else begin
        if (read_value_o !== awaited_words[0].value)
          report_mismatch("read_value", read_value_o, awaited_words[0].value);
        if (status_o !== awaited_words[0].status)
          report_mismatch("status", 32'(status_o), 32'(awaited_words[0].status));
        void'(awaited_words.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if (!long_hold_done && words_in >= 400) begin
      hold_left = 300;
      long_hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (quiet_stretch()) begin
      out_stall_i <= 1'b0;
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      case ($urandom_range(0, 19))
        0: begin
          out_stall_i <= 1'b1;
          burst_left = $urandom_range(10, 50);
        end
        1, 2, 3, 4, 5, 6: begin
          out_stall_i <= 1'b1;
          burst_left = $urandom_range(0, 2);
        end
        default: begin
          out_stall_i <= 1'b0;
          burst_left = $urandom_range(0, 6);
        end
      endcase
    end
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    row_t plan[$];
    int unsigned phase;
    plan.push_back(typed_row(word_row(CMD_LOAD_ELEM, 10'd0, 32'h7fff_ffff, '0, '0, '0),
                             '0, STATUS_OK));
    plan.push_back(typed_row(word_row(CMD_READ_ELEM, 10'd0, '0, '0, '0, '0),
                             32'h7fff_ffff, STATUS_OK));
    plan.push_back(typed_row(word_row(CMD_LOAD_ELEM, 10'd0, 32'h8000_0000, '0, '0, '0),
                             '0, STATUS_OK));
    plan.push_back(typed_row(word_row(CMD_READ_ELEM, 10'd0, '1, '1, '1, '1),
                             32'h8000_0000, STATUS_OK));
    plan.push_back(typed_row(word_row(CMD_LOAD_ELEM, 10'd1, '1, '0, '0, '0), '0, STATUS_RANGE));
    plan.push_back(typed_row(word_row(CMD_READ_ELEM, 10'd1023, '0, '0, '0, '0),
                             '0, STATUS_RANGE));
    plan.push_back(typed_row(word_row(CMD_LOAD_GROUP, 10'd256, '0, 11'd1, 11'd1, '0),
                             '0, STATUS_RANGE));
    plan.push_back(typed_row(word_row(CMD_LOAD_GROUP, 10'd1023, '1, '1, '1, '1),
                             '0, STATUS_RANGE));
    plan.push_back(typed_row(word_row(CMD_LOAD_GROUP, 10'd255, '0, 11'd1024, 11'd1024,
                                      31'h7fff_ffff), '0, STATUS_OK));
    plan.push_back(typed_row(word_row(CMD_RUN, '0, '0, '0, '0, '0), '0, STATUS_OK));
    plan.push_back(typed_row(word_row(CMD_READ_ELEM, 10'd0, '0, '0, '0, '0),
                             32'h8000_0000, STATUS_OK));
    plan.push_back(reg_row(REG_ELEMENT_COUNT, 31'd4));
    plan.push_back(reg_row(REG_GROUP_COUNT, 31'd3));
    plan.push_back(reg_row(REG_L1_ENABLE, 31'd1));
    plan.push_back(reg_row(REG_L1_THRESHOLD, 31'h8000));
    plan.push_back(word_row(CMD_LOAD_ELEM, 10'd0, 32'h0003_0000, '0, '0, '0));
    plan.push_back(word_row(CMD_LOAD_ELEM, 10'd1, 32'hfffe_0000, '0, '0, '0));
    plan.push_back(word_row(CMD_LOAD_ELEM, 10'd2, 32'h0000_4000, '0, '0, '0));
    plan.push_back(word_row(CMD_LOAD_ELEM, 10'd3, 32'h7fff_ffff, '0, '0, '0));
    // The second group overlaps the first; the third is empty.
    plan.push_back(word_row(CMD_LOAD_GROUP, 10'd0, '0, 11'd1, 11'd2, 31'h1_0000));
    plan.push_back(word_row(CMD_LOAD_GROUP, 10'd1, '0, 11'd2, 11'd4, 31'd0));
    plan.push_back(word_row(CMD_LOAD_GROUP, 10'd2, '0, 11'd3, 11'd2, 31'd5));
    plan.push_back(word_row(CMD_RUN, '0, '0, '0, '0, '0));
    for (int j = 0; j < 4; j++) plan.push_back(word_row(CMD_READ_ELEM, 10'(j), '0, '0, '0, '0));
    plan.push_back(word_row(CMD_LOAD_GROUP, 10'd2, '0, 11'd0, 11'd3, 31'd0));
    plan.push_back(typed_row(word_row(CMD_RUN, '0, '0, '0, '0, '0), '0, STATUS_TABLE));
    plan.push_back(word_row(CMD_LOAD_GROUP, 10'd2, '0, 11'd2, 11'd5, 31'd0));
    plan.push_back(typed_row(word_row(CMD_RUN, '0, '0, '0, '0, '0), '0, STATUS_TABLE));
    plan.push_back(word_row(CMD_READ_ELEM, 10'd1, '0, '0, '0, '0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (!plan[i - 1].is_cfg) drain();
        write_reg(plan[i].code, plan[i].value[30:0]);
      end else begin
        send_word(plan[i]);
      end
    end
    phase = 1;
    while (words_in < ItemTarget) begin
      random_phase(phase);
      phase++;
    end
    drain();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/glp_pkg.sv
hw/rtl/glp_root_div.sv
hw/rtl/group_lasso_proximal_operator_unit.sv
bench/group_lasso_proximal_operator_unit_tb.sv
